FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the motor PWM core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Invariant: prop holds at every clock edge out of reset
`define FMP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("motor pwm invariant violated");
// Implication checked in the same cycle
`define FMP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("motor pwm implication violated");
`else
`define FMP_ASSERT(lbl, clk, rstn, prop)
`define FMP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/fmp_pkg.sv
// Types and constants of the four-channel motor PWM core
package fmp_pkg;

    localparam int MASK_W    = 4;    // width of the channel masks and enable register
    localparam int CHAN_W    = 2;
    localparam int SPEED_W   = 8;
    localparam int MAG_W     = 7;
    localparam int STEP_W    = 7;
    localparam int DUTY_W    = 8;
    localparam int SPEED_MAX = 127;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_SPEED = 1'b1
    } t_kind;

    typedef logic [MASK_W-1:0]         t_mask;
    typedef logic signed [SPEED_W-1:0] t_speed;

endpackage

FILE: rtl/core/fmp_ifs.sv
// Valid/ready channel interfaces for the motor PWM core
interface fmp_item_if;
    import fmp_pkg::*;

    logic                valid;
    logic                ready;
    t_kind               kind;
    logic [CHAN_W-1:0]   channel;
    t_speed              speed;

    modport source (output valid, output kind, output channel, output speed, input ready);
    modport sink   (input valid, input kind, input channel, input speed, output ready);
endinterface

interface fmp_result_if;
    import fmp_pkg::*;

    logic  valid;
    logic  ready;
    t_mask m1_mask;
    t_mask m2_mask;
    t_mask changed_mask;

    modport source (output valid, output m1_mask, output m2_mask, output changed_mask,
                    input ready);
    modport sink   (input valid, input m1_mask, input m2_mask, input changed_mask,
                    output ready);
endinterface

FILE: rtl/core/four_channel_motor_pwm_core.sv
// Four-channel sign-magnitude PWM core for H-bridge motor pins
//
//  port          | dir | transfer carries
//  --------------+-----+-------------------------------------------
//  i_item        | in  | tick or set-speed command (kind, channel, speed)
//  o_result      | out | M1/M2 pin masks and changed mask, one per tick
//  i_cfg_*       | in  | enable mask write, one register
//
// One item per cycle while ready is high: a tick is evaluated combinationally from the stored
// speeds, a duty table lookup per channel and the shared step counter.
// Results sit in an output register backed by one skid entry, so an item is
// still taken while one result waits; ready drops only when both are full.
// Synchronous active-low reset clears counter, speeds, pins and enables.
`include "assert_macros.svh"

module four_channel_motor_pwm_core #(
    parameter int CHANNELS = 4,
    parameter int STEPS    = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fmp_pkg::MASK_W-1:0]    i_cfg_wdata,
    fmp_item_if.sink                      i_item,
    fmp_result_if.source                  o_result
);
    import fmp_pkg::*;

    // channels beyond the enable register are never driven
    localparam int ACTIVE = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
    localparam int TAB_N  = 1 << MAG_W;

    typedef logic [TAB_N-1:0][DUTY_W-1:0] t_duty_tab;

    typedef struct packed {
        t_mask m1;
        t_mask m2;
        t_mask chg;
    } t_result;

    function automatic t_duty_tab duty_tab_f();
        t_duty_tab tab;
        for (int m = 0; m < TAB_N; m++) begin
            tab[m] = DUTY_W'((m * STEPS) / SPEED_MAX);
        end
        return tab;
    endfunction

    localparam t_duty_tab DUTY_TAB = duty_tab_f();

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_mask             r_enable;
    t_speed            r_speed [ACTIVE];
    logic [1:0]        r_pin   [ACTIVE];
    logic [1:0]        n_pin   [ACTIVE];

    t_result r_out;
    logic    r_out_v;
    t_result r_skid;
    logic    r_skid_v;

    logic    in_fire;
    logic    out_fire;
    logic    tick_fire;
    t_speed  speed_clamped;
    t_result res;
    t_mask   pin_m1_now;
    t_mask   pin_m2_now;
    logic [STEP_W:0] step_inc;

    assign in_fire   = i_item.valid && i_item.ready;
    assign out_fire  = r_out_v && o_result.ready;
    assign tick_fire = in_fire && (i_item.kind == KIND_TICK);

    assign i_item.ready          = !r_skid_v;
    assign o_result.valid        = r_out_v;
    assign o_result.m1_mask      = r_out.m1;
    assign o_result.m2_mask      = r_out.m2;
    assign o_result.changed_mask = r_out.chg;

    // -128 has no positive twin: clamp it to -127
    assign speed_clamped = (i_item.speed == t_speed'(-(SPEED_MAX + 1)))
                         ? t_speed'(-SPEED_MAX) : i_item.speed;

    always_comb begin
        step_inc = {1'b0, r_step} + 1'b1;
        n_step   = (32'(step_inc) >= STEPS) ? '0 : step_inc[STEP_W-1:0];
    end

    always_comb begin
        logic [SPEED_W-1:0] mag;
        logic [DUTY_W-1:0]  duty;
        logic [1:0]         want;
        res        = '0;
        pin_m1_now = '0;
        pin_m2_now = '0;
        for (int c = 0; c < ACTIVE; c++) begin
            mag  = r_speed[c][SPEED_W-1] ? SPEED_W'(-r_speed[c]) : r_speed[c];
            duty = DUTY_TAB[mag[MAG_W-1:0]];
            want = 2'b00;
            if (DUTY_W'(r_step) < duty) begin
                want = r_speed[c][SPEED_W-1] ? 2'b10 : 2'b01;
            end
            n_pin[c] = r_enable[c] ? want : r_pin[c];
            res.chg[c] = r_enable[c] && (want != r_pin[c]);
            res.m1[c]  = n_pin[c][0];
            res.m2[c]  = n_pin[c][1];
            pin_m1_now[c] = r_pin[c][0];
            pin_m2_now[c] = r_pin[c][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_enable <= '0;
            for (int c = 0; c < ACTIVE; c++) begin
                r_speed[c] <= '0;
                r_pin[c]   <= 2'b00;
            end
        end else if (i_cfg_we) begin
            // clear speed and pins of every channel whose enable flips
            r_enable <= i_cfg_wdata;
            for (int c = 0; c < ACTIVE; c++) begin
                if (i_cfg_wdata[c] != r_enable[c]) begin
                    r_speed[c] <= '0;
                    r_pin[c]   <= 2'b00;
                end
            end
        end else if (in_fire) begin
            if (i_item.kind == KIND_SPEED) begin
                for (int c = 0; c < ACTIVE; c++) begin
                    if ((32'(i_item.channel) == c) && r_enable[c]) begin
                        r_speed[c] <= speed_clamped;
                    end
                end
            end else begin
                r_step <= n_step;
                for (int c = 0; c < ACTIVE; c++) begin
                    r_pin[c] <= n_pin[c];
                end
            end
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_fire) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (tick_fire) begin
            if (!r_out_v || out_fire) begin
                r_out   <= res;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= res;
                r_skid_v <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_v <= 1'b0;
        end
    end

    `FMP_ASSERT(a_pins_exclusive, i_clk, i_rst_n, (pin_m1_now & pin_m2_now) == '0)
    `FMP_ASSERT(a_disabled_low, i_clk, i_rst_n, ((pin_m1_now | pin_m2_now) & ~r_enable) == '0)
    `FMP_ASSERT(a_step_range, i_clk, i_rst_n, 32'(r_step) < STEPS)
    `FMP_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)

endmodule
